FILE: design/setq_pkg.sv
// Shared types and constants of the sorted expiry timer queue.
// No dependencies; every other design file but setq_ram refers to it by scoped names.
package setq_pkg;

  // Fixed field widths of the item and result channels.
  localparam int MODE_W    = 2;
  localparam int ID_W      = 4;
  localparam int TIME_IN_W = 32;
  localparam int TAG_W     = 16;

  // Defaults for the top-level parameters.
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Operation carried by one input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

endpackage

FILE: design/setq_if.sv
// Valid/ready channel interfaces for timer operations and expired timers.
// Depends on setq_pkg for the field widths.
interface setq_in_if;
  logic                              valid;
  logic                              ready;
  logic [setq_pkg::MODE_W-1:0]       mode;
  logic [setq_pkg::ID_W-1:0]         timer_id;
  logic [setq_pkg::TIME_IN_W-1:0]    expiry_time;
  logic [setq_pkg::TAG_W-1:0]        user_tag;
  logic [setq_pkg::TIME_IN_W-1:0]    now_time;

  modport source (output valid, mode, timer_id, expiry_time, user_tag, now_time,
                  input ready);
  modport sink   (input valid, mode, timer_id, expiry_time, user_tag, now_time,
                  output ready);
endinterface

interface setq_out_if;
  logic                        valid;
  logic                        ready;
  logic [setq_pkg::ID_W-1:0]   expired_id;
  logic [setq_pkg::TAG_W-1:0]  expired_tag;
  logic                        last_expired;

  modport source (output valid, expired_id, expired_tag, last_expired, input ready);
  modport sink   (input valid, expired_id, expired_tag, last_expired, output ready);
endinterface

FILE: design/setq_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module setq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/setq_ctrl.sv
// Sequencer of the timer queue: walks the order RAM and the slot RAMs, keeps the
// slot active bits, the entry count and the result register. Uses setq_pkg, setq_if.
module setq_ctrl #(
  parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = setq_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  setq_in_if.sink                       in_ch,
  setq_out_if.source                    out_ch,
  output logic                          ord_we,
  output logic [$clog2(NUM_TIMERS)-1:0] ord_waddr,
  output logic [$clog2(NUM_TIMERS)-1:0] ord_wdata,
  output logic [$clog2(NUM_TIMERS)-1:0] ord_raddr,
  input  logic [$clog2(NUM_TIMERS)-1:0] ord_rdata,
  output logic                          exp_we,
  output logic                          tag_we,
  output logic [$clog2(NUM_TIMERS)-1:0] slot_waddr,
  output logic [TIME_BITS-1:0]          exp_wdata,
  output logic [setq_pkg::TAG_W-1:0]    tag_wdata,
  output logic [$clog2(NUM_TIMERS)-1:0] slot_raddr,
  input  logic [TIME_BITS-1:0]          exp_rdata,
  input  logic [setq_pkg::TAG_W-1:0]    tag_rdata
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEL_CHK,
    S_INS_START,
    S_INS_RS,
    S_INS_CMP,
    S_INS_PUT,
    S_TK_RS,
    S_TK_CMP,
    S_TK_FLUSH,
    S_SH_MV
  } state_t;

  state_t                        state_r,     state_nxt;
  setq_pkg::mode_t               mode_r,      mode_nxt;
  logic [IW-1:0]                 id_r,        id_nxt;
  logic [TIME_BITS-1:0]          time_r,      time_nxt;
  logic [CW-1:0]                 cnt_r,       cnt_nxt;
  logic [CW-1:0]                 i_r,         i_nxt;
  logic [CW-1:0]                 s_r,         s_nxt;
  logic                          found_r,     found_nxt;
  logic [IW-1:0]                 prev_r,      prev_nxt;
  logic                          has_r,       has_nxt;
  logic [IW-1:0]                 hold_id_r,   hold_id_nxt;
  logic [setq_pkg::TAG_W-1:0]    hold_tag_r,  hold_tag_nxt;
  logic [NUM_TIMERS-1:0]         active_r,    active_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [setq_pkg::ID_W-1:0]     out_id_r,    out_id_nxt;
  logic [setq_pkg::TAG_W-1:0]    out_tag_r,   out_tag_nxt;
  logic                          out_last_r,  out_last_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic                          push;
  logic                          push_last;
  setq_pkg::mode_t               in_mode;
  logic [IW-1:0]                 in_slot;
  logic                          id_ok;
  logic [TIME_BITS-1:0]          exp_in;
  logic [TIME_BITS-1:0]          now_in;
  logic [CW-1:0]                 i_inc, i_dec, i_dec2, s_inc, s_minus_k, cnt_inc, cnt_dec;
  logic                          is_late;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign in_mode             = setq_pkg::mode_t'(in_ch.mode);
  assign in_slot             = IW'(in_ch.timer_id);
  assign id_ok               = int'(in_ch.timer_id) < NUM_TIMERS;
  assign exp_in              = TIME_BITS'(in_ch.expiry_time);
  assign now_in              = TIME_BITS'(in_ch.now_time);

  assign i_inc     = i_r + CW'(1);
  assign i_dec     = i_r - CW'(1);
  assign i_dec2    = i_r - CW'(2);
  assign s_inc     = s_r + CW'(1);
  assign s_minus_k = s_r - i_r;
  assign cnt_inc   = cnt_r + CW'(1);
  assign cnt_dec   = cnt_r - CW'(1);

  // The held time is strictly earlier than the expiry read from the slot RAM.
  assign is_late   = time_r < exp_rdata;

  // Slot RAM writes only happen in the cycle an add or adjust is accepted.
  assign slot_waddr = in_slot;
  assign exp_wdata  = exp_in;
  assign tag_wdata  = in_ch.user_tag;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.expired_id   = out_id_r;
  assign out_ch.expired_tag  = out_tag_r;
  assign out_ch.last_expired = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    id_nxt       = id_r;
    time_nxt     = time_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    s_nxt        = s_r;
    found_nxt    = found_r;
    prev_nxt     = prev_r;
    has_nxt      = has_r;
    hold_id_nxt  = hold_id_r;
    hold_tag_nxt = hold_tag_r;
    active_nxt   = active_r;
    ord_we       = 1'b0;
    ord_waddr    = i_r[IW-1:0];
    ord_wdata    = prev_r;
    ord_raddr    = '0;
    exp_we       = 1'b0;
    tag_we       = 1'b0;
    slot_raddr   = prev_r;
    push         = 1'b0;
    push_last    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt = in_mode;
          id_nxt   = in_slot;
          time_nxt = (in_mode == setq_pkg::MODE_TICK) ? now_in : exp_in;
          case (in_mode)
            setq_pkg::MODE_TICK: begin
              if (cnt_r != '0) begin
                i_nxt     = '0;
                has_nxt   = 1'b0;
                ord_raddr = '0;
                state_nxt = S_TK_RS;
              end
            end
            setq_pkg::MODE_ADD: begin
              if (id_ok && !active_r[in_slot] && (cnt_r != CW'(NUM_TIMERS))) begin
                exp_we              = 1'b1;
                tag_we              = 1'b1;
                active_nxt[in_slot] = 1'b1;
                i_nxt               = cnt_r;
                state_nxt           = S_INS_START;
              end
            end
            default: begin
              // Adjust and delete both first take the timer out of the list.
              if (id_ok && active_r[in_slot]) begin
                i_nxt     = '0;
                found_nxt = 1'b0;
                ord_raddr = '0;
                if (in_mode == setq_pkg::MODE_DELETE) begin
                  active_nxt[in_slot] = 1'b0;
                end else begin
                  exp_we = 1'b1;
                end
                state_nxt = S_DEL_CHK;
              end
            end
          endcase
        end
      end

      S_DEL_CHK: begin
        // Entries behind the removed one move up by one place.
        if (found_r) begin
          ord_we    = 1'b1;
          ord_waddr = i_dec[IW-1:0];
          ord_wdata = ord_rdata;
        end
        found_nxt = found_r || (ord_rdata == id_r);
        if (i_inc == cnt_r) begin
          cnt_nxt = cnt_dec;
          if (mode_r == setq_pkg::MODE_ADJUST) begin
            i_nxt     = cnt_dec;
            state_nxt = S_INS_START;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          i_nxt     = i_inc;
          ord_raddr = i_inc[IW-1:0];
        end
      end

      S_INS_START: begin
        if (i_r == '0) begin
          ord_we    = 1'b1;
          ord_wdata = id_r;
          cnt_nxt   = cnt_inc;
          state_nxt = S_IDLE;
        end else begin
          ord_raddr = i_dec[IW-1:0];
          state_nxt = S_INS_RS;
        end
      end

      S_INS_RS: begin
        prev_nxt   = ord_rdata;
        slot_raddr = ord_rdata;
        state_nxt  = S_INS_CMP;
      end

      S_INS_CMP: begin
        ord_we = 1'b1;
        if (is_late) begin
          // The new timer goes in front of this entry: shift it back one place.
          ord_wdata = prev_r;
          i_nxt     = i_dec;
          if (i_dec == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            ord_raddr = i_dec2[IW-1:0];
            state_nxt = S_INS_RS;
          end
        end else begin
          ord_wdata = id_r;
          cnt_nxt   = cnt_inc;
          state_nxt = S_IDLE;
        end
      end

      S_INS_PUT: begin
        ord_we    = 1'b1;
        ord_wdata = id_r;
        cnt_nxt   = cnt_inc;
        state_nxt = S_IDLE;
      end

      S_TK_RS: begin
        prev_nxt   = ord_rdata;
        slot_raddr = ord_rdata;
        state_nxt  = S_TK_CMP;
      end

      S_TK_CMP: begin
        if (!is_late) begin
          // One expired timer is held back so the last one of the tick can be marked.
          if (!has_r || out_free) begin
            push                 = has_r;
            hold_id_nxt          = prev_r;
            hold_tag_nxt         = tag_rdata;
            has_nxt              = 1'b1;
            active_nxt[prev_r]   = 1'b0;
            i_nxt                = i_inc;
            if (i_inc == cnt_r) begin
              state_nxt = S_TK_FLUSH;
            end else begin
              ord_raddr = i_inc[IW-1:0];
              state_nxt = S_TK_RS;
            end
          end
        end else begin
          state_nxt = S_TK_FLUSH;
        end
      end

      S_TK_FLUSH: begin
        if (!has_r || out_free) begin
          push      = has_r;
          push_last = 1'b1;
          has_nxt   = 1'b0;
          if (i_r == '0) begin
            state_nxt = S_IDLE;
          end else if (i_r == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            s_nxt     = i_r;
            ord_raddr = i_r[IW-1:0];
            state_nxt = S_SH_MV;
          end
        end
      end

      S_SH_MV: begin
        // Close the gap left by the popped timers, one entry a cycle.
        ord_we    = 1'b1;
        ord_waddr = s_minus_k[IW-1:0];
        ord_wdata = ord_rdata;
        if (s_inc == cnt_r) begin
          cnt_nxt   = cnt_r - i_r;
          state_nxt = S_IDLE;
        end else begin
          s_nxt     = s_inc;
          ord_raddr = s_inc[IW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = setq_pkg::ID_W'(hold_id_r);
      out_tag_nxt   = hold_tag_r;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= '0;
      has_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      has_r       <= has_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    time_r     <= time_nxt;
    i_r        <= i_nxt;
    s_r        <= s_nxt;
    prev_r     <= prev_nxt;
    hold_id_r  <= hold_id_nxt;
    hold_tag_r <= hold_tag_nxt;
    out_id_r   <= out_id_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_TIMERS))
    else $error("entry count exceeds the number of timers");

  a_active_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(active_r) == int'(cnt_r)))
    else $error("active slots and entry count disagree while idle");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed while the result register is occupied");

  a_delete_finds_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_CHK && i_inc == cnt_r) |-> (found_r || ord_rdata == id_r))
    else $error("active timer missing from the order list");
`endif

endmodule

FILE: design/sorted_expiry_timer_queue_top.sv
// Top level of the sorted expiry timer queue: sequencer plus order, expiry and tag RAMs.
// Depends on setq_pkg, setq_if, setq_ram and setq_ctrl.
//
//   Channel  | Dir | Contents                                          | Transfer
//   ---------+-----+---------------------------------------------------+--------------------
//   in_chan  | in  | mode, timer_id, expiry_time, user_tag, now_time    | valid & ready
//   out_chan | out | expired_id, expired_tag, last_expired              | valid & ready
//
// One item is worked at a time. Each step of a walk is one read of the order RAM and,
// when times are compared, one read of the expiry RAM, so the single read port of the
// order RAM paces the walk.
// Reset (rst_n low at a clock edge) empties the queue; the RAMs are not cleared.
// A stalled result holds in the output register while the walk waits at its next result;
// in_chan.ready is high whenever the sequencer is idle, even with a result still waiting.
module sorted_expiry_timer_queue_top #(
  parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = setq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  setq_in_if.sink     in_chan,
  setq_out_if.source  out_chan
);

  localparam int IW = $clog2(NUM_TIMERS);

  // Order RAM: timer ids in queue order, front at address zero.
  logic                       ord_we;
  logic [IW-1:0]              ord_waddr;
  logic [IW-1:0]              ord_wdata;
  logic [IW-1:0]              ord_raddr;
  logic [IW-1:0]              ord_rdata;

  // Slot RAMs: expiry and tag per timer id, sharing their addresses.
  logic                       exp_we;
  logic                       tag_we;
  logic [IW-1:0]              slot_waddr;
  logic [TIME_BITS-1:0]       exp_wdata;
  logic [setq_pkg::TAG_W-1:0] tag_wdata;
  logic [IW-1:0]              slot_raddr;
  logic [TIME_BITS-1:0]       exp_rdata;
  logic [setq_pkg::TAG_W-1:0] tag_rdata;

  setq_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .out_ch     (out_chan),
    .ord_we     (ord_we),
    .ord_waddr  (ord_waddr),
    .ord_wdata  (ord_wdata),
    .ord_raddr  (ord_raddr),
    .ord_rdata  (ord_rdata),
    .exp_we     (exp_we),
    .tag_we     (tag_we),
    .slot_waddr (slot_waddr),
    .exp_wdata  (exp_wdata),
    .tag_wdata  (tag_wdata),
    .slot_raddr (slot_raddr),
    .exp_rdata  (exp_rdata),
    .tag_rdata  (tag_rdata)
  );

  // The sequencer never uses read data of an order entry written in the same cycle, so
  // the RAMs need no bypass path.
  setq_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (IW)
  ) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  setq_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (TIME_BITS)
  ) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (slot_waddr),
    .wdata (exp_wdata),
    .raddr (slot_raddr),
    .rdata (exp_rdata)
  );

  setq_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (setq_pkg::TAG_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot_waddr),
    .wdata (tag_wdata),
    .raddr (slot_raddr),
    .rdata (tag_rdata)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sorted expiry timer queue: a directed table, then random
// timer traffic in three idling phases, checked against a local timer-list predictor.
// Depends on setq_pkg, setq_if and sorted_expiry_timer_queue_top.
module testbench;

  localparam int NT             = setq_pkg::NUM_TIMERS_DEF;
  // Longest single item is an adjust on a full list.
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int LIMIT_CYCLES   = 300000;
  localparam int PRINT_LIMIT    = 40;

  // How a table row gets its expected results.
  localparam int USE_MODEL   = -1;
  localparam int EXPECT_NONE = 0;
  localparam int EXPECT_ONE  = 1;

  typedef struct packed {
    logic [setq_pkg::ID_W-1:0]  id;
    logic [setq_pkg::TAG_W-1:0] tag;
    logic                       last;
  } expired_rec_t;

  typedef struct {
    setq_pkg::mode_t                mode;
    logic [setq_pkg::ID_W-1:0]      id;
    logic [setq_pkg::TIME_IN_W-1:0] expiry;
    logic [setq_pkg::TAG_W-1:0]     tag;
    logic [setq_pkg::TIME_IN_W-1:0] now;
    int                             typed_n;
    expired_rec_t                   typed;
  } timer_op_t;

  localparam expired_rec_t NO_REC = '0;
  localparam int DIR_N = 23;

  logic clk = 1'b0;
  logic rst_n;

  setq_in_if  in_chan();
  setq_out_if out_chan();

  sorted_expiry_timer_queue_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the timer list: ids in expiry order plus per-slot data.
  logic [setq_pkg::ID_W-1:0]      list_order [NT];
  int                             list_count;
  logic [setq_pkg::TIME_IN_W-1:0] slot_time  [NT];
  logic [setq_pkg::TAG_W-1:0]     slot_ref   [NT];
  bit                             slot_live  [NT];

  expired_rec_t popped_now [$];
  expired_rec_t pending_expiries [$];
  bit           op_effect;

  int           mismatch_count;
  int           effective_count;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;
  bit           hold_done;
  int           hold_left;
  int unsigned  cycle_count;
  logic [setq_pkg::TIME_IN_W-1:0] time_base;
  timer_op_t    dir_ops [DIR_N];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
    end
  endtask

  task automatic drop_entry(input int pos);
    for (int k = pos; k + 1 < list_count; k++) list_order[k] = list_order[k + 1];
    if (list_count > 0) list_count--;
  endtask

  // A timer goes after every entry whose expiry is not later than its own, so equal
  // times stay in arrival order.
  task automatic insert_sorted(input logic [setq_pkg::ID_W-1:0] id);
    int pos;
    pos = 0;
    while (pos < list_count && !(slot_time[id] < slot_time[list_order[pos]])) pos++;
    for (int k = list_count; k > pos; k--) list_order[k] = list_order[k - 1];
    list_order[pos] = id;
    list_count++;
  endtask

  // Applies one accepted item to the predictor; popped timers land in popped_now and
  // op_effect says whether the item changed anything at all.
  task automatic advance_timer_list(input timer_op_t op);
    int pos;
    popped_now.delete();
    op_effect = 1'b1;
    if (op.mode == setq_pkg::MODE_TICK) begin
      while (list_count > 0 && slot_time[list_order[0]] <= op.now) begin
        popped_now.push_back('{list_order[0], slot_ref[list_order[0]], 1'b0});
        slot_live[list_order[0]] = 1'b0;
        drop_entry(0);
      end
      if (popped_now.size() > 0) popped_now[popped_now.size() - 1].last = 1'b1;
    end else if (op.mode == setq_pkg::MODE_ADD) begin
      if (slot_live[op.id] || list_count >= NT) begin
        op_effect = 1'b0;
      end else begin
        slot_time[op.id] = op.expiry;
        slot_ref[op.id]  = op.tag;
        slot_live[op.id] = 1'b1;
        insert_sorted(op.id);
      end
    end else if (!slot_live[op.id]) begin
      op_effect = 1'b0;
    end else begin
      pos = 0;
      while (list_order[pos] != op.id) pos++;
      drop_entry(pos);
      if (op.mode == setq_pkg::MODE_ADJUST) begin
        // The stored tag is kept; only the expiry moves.
        slot_time[op.id] = op.expiry;
        insert_sorted(op.id);
      end else begin
        slot_live[op.id] = 1'b0;
      end
    end
  endtask

  // Offers one item at a falling edge, after a random idle gap, and holds it until the
  // transfer. The predictor runs at the accepting edge, so expectations keep input order.
  task automatic send_op(input timer_op_t op);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.mode        <= op.mode;
    in_chan.timer_id    <= op.id;
    in_chan.expiry_time <= op.expiry;
    in_chan.user_tag    <= op.tag;
    in_chan.now_time    <= op.now;
    in_chan.valid       <= 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    advance_timer_list(op);
    if (op.typed_n == USE_MODEL) begin
      foreach (popped_now[i]) pending_expiries.push_back(popped_now[i]);
    end else if (op.typed_n == EXPECT_ONE) begin
      pending_expiries.push_back(op.typed);
    end
    if (op_effect) effective_count++;
  endtask

  // Drops valid, waits for every expected result, then lets the last item finish.
  task automatic settle_block();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_expiries.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly times close to the running clock, with ties to queued timers, the extremes
  // and fully random values mixed in.
  function automatic logic [setq_pkg::TIME_IN_W-1:0] pick_expiry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    if (r < 11) return '0;
    if (r < 14) return '1;
    if (r < 30 && list_count > 0) return slot_time[list_order[$urandom_range(0, list_count - 1)]];
    return time_base + $urandom_range(0, 60);
  endfunction

  // Usually an id that makes the operation take effect, sometimes any id at all.
  function automatic logic [setq_pkg::ID_W-1:0] pick_id(input bit want_live);
    int cands [$];
    for (int i = 0; i < NT; i++) if (slot_live[i] == want_live) cands.push_back(i);
    if (cands.size() > 0 && $urandom_range(0, 99) < 85) begin
      return setq_pkg::ID_W'(cands[$urandom_range(0, cands.size() - 1)]);
    end
    return setq_pkg::ID_W'($urandom_range(0, NT - 1));
  endfunction

  task automatic make_random_op(output timer_op_t op);
    int r;
    r = $urandom_range(0, 99);
    op.expiry  = $urandom;
    op.tag     = setq_pkg::TAG_W'($urandom_range(0, 65535));
    op.now     = $urandom;
    op.typed_n = USE_MODEL;
    op.typed   = NO_REC;
    if (r < 35) begin
      op.mode   = setq_pkg::MODE_ADD;
      op.id     = pick_id(1'b0);
      op.expiry = pick_expiry();
    end else if (r < 50) begin
      op.mode   = setq_pkg::MODE_ADJUST;
      op.id     = pick_id(1'b1);
      op.expiry = pick_expiry();
    end else if (r < 60) begin
      op.mode = setq_pkg::MODE_DELETE;
      op.id   = pick_id(1'b1);
    end else begin
      op.mode   = setq_pkg::MODE_TICK;
      op.id     = setq_pkg::ID_W'($urandom_range(0, NT - 1));
      time_base = time_base + $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      if (r < 8) op.now = $urandom;
      else if (r < 12) op.now = '1;
      else op.now = time_base;
    end
  endtask

  // One idling phase: fill the list to the brim, try one add too many, optionally make
  // the receiver hold off while a full drain is pending, then random traffic.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int quota,
                           input bit with_hold);
    timer_op_t op;
    tx_idle_pct     = tx_pct;
    rx_idle_pct     = rx_pct;
    effective_count = 0;
    op.typed_n      = USE_MODEL;
    op.typed        = NO_REC;
    op.now          = $urandom;
    for (int i = 0; i < NT; i++) begin
      if (!slot_live[i]) begin
        op.mode   = setq_pkg::MODE_ADD;
        op.id     = setq_pkg::ID_W'(i);
        op.expiry = pick_expiry();
        op.tag    = setq_pkg::TAG_W'($urandom_range(0, 65535));
        send_op(op);
      end
    end
    op.mode = setq_pkg::MODE_ADD;
    op.id   = setq_pkg::ID_W'($urandom_range(0, NT - 1));
    send_op(op);
    if (with_hold) begin
      // Sixteen results fall due behind a stalled receiver, so the tick waits on the result register.
      hold_req = 1'b1;
      op.mode  = setq_pkg::MODE_TICK;
      op.now   = '1;
      send_op(op);
    end
    while (effective_count < quota) begin
      make_random_op(op);
      send_op(op);
    end
    settle_block();
  endtask

  // Receiver: random stalls at the falling edge, plus one long hold-off when asked.
  initial begin
    out_chan.ready = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Every result transfer is checked against the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    expired_rec_t want;
    if (rst_n === 1'b1 && out_chan.valid && out_chan.ready) begin
      if (pending_expiries.size() == 0) begin
        report_mismatch("unexpected result, id", 32'd0, 32'(out_chan.expired_id));
      end else begin
        want = pending_expiries.pop_front();
        if (out_chan.expired_id !== want.id)
          report_mismatch("expired_id", 32'(want.id), 32'(out_chan.expired_id));
        if (out_chan.expired_tag !== want.tag)
          report_mismatch("expired_tag", 32'(want.tag), 32'(out_chan.expired_tag));
        if (out_chan.last_expired !== want.last)
          report_mismatch("last_expired", 32'(want.last), 32'(out_chan.last_expired));
      end
    end
  end

  // Watchdog: the run must end well before this many cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.mode        = setq_pkg::MODE_ADD;
    in_chan.timer_id    = '0;
    in_chan.expiry_time = '0;
    in_chan.user_tag    = '0;
    in_chan.now_time    = '0;
    rst_n               = 1'b0;
    mismatch_count      = 0;
    effective_count     = 0;
    tx_idle_pct         = 26;
    rx_idle_pct         = 79;
    hold_req            = 1'b0;
    time_base           = 32'd1000;
    list_count          = 0;
    for (int i = 0; i < NT; i++) begin
      list_order[i] = '0;
      slot_time[i]  = '0;
      slot_ref[i]   = '0;
      slot_live[i]  = 1'b0;
    end

    // Directed rows: empty tick after reset, both time extremes, ties in arrival order,
    // duplicate add, adjust later and earlier (tag kept), adjust and delete of absent ids,
    // and a tick on a list with nothing left.
    dir_ops = '{
      '{setq_pkg::MODE_TICK, 4'd0, 32'h0000_0000, 16'h0000, 32'h0000_0000, EXPECT_NONE, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd0, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, EXPECT_ONE,
        '{4'd0, 16'h0000, 1'b1}},
      '{setq_pkg::MODE_ADD, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_TICK, 4'd15, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFE, EXPECT_NONE,
        NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, EXPECT_ONE,
        '{4'd15, 16'hFFFF, 1'b1}},
      '{setq_pkg::MODE_ADD, 4'd3, 32'd100, 16'h1234, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd3, 32'd50, 16'h5555, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd5, 32'd100, 16'hA5A5, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd7, 32'd100, 16'h0F0F, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd1, 32'd20, 16'h0001, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADJUST, 4'd1, 32'd200, 16'h7777, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADJUST, 4'd7, 32'd10, 16'hFFFF, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADJUST, 4'd9, 32'd5, 16'h0000, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_DELETE, 4'd5, 32'd0, 16'h0000, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_DELETE, 4'd5, 32'd0, 16'h0000, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'd0, 16'h0000, 32'd99, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd12, 32'd200, 16'hC3C3, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'd0, 16'h0000, 32'd1000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'd0, 16'h0000, 32'd1000, EXPECT_NONE, NO_REC},
      '{setq_pkg::MODE_ADD, 4'd10, 32'h8000_0000, 16'h8000, 32'h0000_0000, USE_MODEL, NO_REC},
      '{setq_pkg::MODE_ADJUST, 4'd10, 32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, USE_MODEL,
        NO_REC},
      '{setq_pkg::MODE_TICK, 4'd0, 32'd0, 16'h0000, 32'h7FFF_FFFF, EXPECT_ONE,
        '{4'd10, 16'h8000, 1'b1}}
    };

    // Synchronous reset held low over several rising edges, released at a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_ops[i]) send_op(dir_ops[i]);
    settle_block();

    // Sender idles 26 in 100 and receiver 79, then the reverse with the long hold-off,
    // then back-to-back with no idling on either side.
    run_phase(26, 79, 27, 1'b0);
    run_phase(79, 26, 27, 1'b1);
    run_phase(0, 0, 26, 1'b0);

    if (pending_expiries.size() != 0)
      report_mismatch("results never delivered, count", 32'd0, 32'(pending_expiries.size()));

    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/setq_pkg.sv
design/setq_if.sv
design/setq_ram.sv
design/setq_ctrl.sv
design/sorted_expiry_timer_queue_top.sv
tb/testbench.sv
